>>> src/hci_pkg.sv
// Shared constants, types and codes of the HSV colour interpolator.
package hci_pkg;

  localparam int HUE_SECTOR = 3840;
  localparam int HUE_FULL   = 23040;
  localparam int HUE_HALF   = 11520;
  localparam int Q16_ONE    = 65536;
  localparam int HSV_FULL   = Q16_ONE * HUE_SECTOR;

  localparam int DIV_NW     = 24;
  localparam int DIV_QB     = 18;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = DIV_QB / DIV_STEPS;
  localparam int MIX_STAGES = 3;
  localparam int RGB_STAGES = 5;
  localparam int N_STAGES   = 1 + DIV_STAGES + MIX_STAGES + RGB_STAGES;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } sector_t;

  typedef struct packed {
    sector_t     sel;
    logic        neg;
    logic        dzero;
    logic [16:0] v;
  } hsv_side_t;

  typedef struct packed {
    hsv_side_t   a;
    hsv_side_t   b;
    logic [15:0] w;
    logic        bypass;
    logic [23:0] pass;
  } side_t;

  typedef struct packed {
    logic [14:0] h;
    logic [16:0] s;
    logic [16:0] v;
    logic        bypass;
    logic [23:0] pass;
  } mid_t;

endpackage

>>> src/hci_front.sv
// Front end of the RGB to HSV conversion: extremes, value and divider operands.
module hci_front (
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  output logic [hci_pkg::DIV_NW-1:0]  s_num,
  output logic [hci_pkg::DIV_NW-1:0]  h_num,
  output logic [7:0]                  s_den,
  output logic [7:0]                  h_den,
  output hci_pkg::hsv_side_t          side
);
  import hci_pkg::*;

  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  delta;
  logic [7:0]  hi;
  logic [7:0]  lo;
  logic [7:0]  mag;
  logic [19:0] hprod;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;

    priority if (mx == red) begin
      side.sel = SEL_RED;
      hi = green;
      lo = blue;
    end else if (mx == green) begin
      side.sel = SEL_GREEN;
      hi = blue;
      lo = red;
    end else begin
      side.sel = SEL_BLUE;
      hi = red;
      lo = green;
    end
    side.neg   = lo > hi;
    mag        = side.neg ? (lo - hi) : (hi - lo);
    side.dzero = (delta == 8'd0);
    // 257 * max plus one when the top bit rounds up.
    side.v     = 17'({mx, 8'h00}) + 17'(mx) + 17'(mx[7]);

    hprod = 20'(mag) * 20'(HUE_SECTOR);
    h_num = 24'(hprod) + 24'(delta[7:1]);
    s_num = {delta, 16'h0000} + 24'(mx[7:1]);
    s_den = mx;
    h_den = delta;
  end

endmodule

>>> src/hci_div.sv
// Pipelined restoring divider, a few quotient bits in each stage.
module hci_div (
  input  logic                          clk,
  input  logic [hci_pkg::DIV_STAGES-1:0] en,
  input  logic [hci_pkg::DIV_NW-1:0]    num,
  input  logic [7:0]                    den,
  output logic [hci_pkg::DIV_QB-1:0]    quo
);
  import hci_pkg::*;

  logic [7:0]        rem_r   [DIV_STAGES];
  logic [DIV_QB-1:0] n_r     [DIV_STAGES];
  logic [DIV_QB-1:0] q_r     [DIV_STAGES];
  logic [7:0]        d_r     [DIV_STAGES];
  logic [7:0]        rem_src [DIV_STAGES];
  logic [DIV_QB-1:0] n_src   [DIV_STAGES];
  logic [DIV_QB-1:0] q_src   [DIV_STAGES];
  logic [7:0]        d_src   [DIV_STAGES];
  logic [7:0]        rem_nxt [DIV_STAGES];
  logic [DIV_QB-1:0] n_nxt   [DIV_STAGES];
  logic [DIV_QB-1:0] q_nxt   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      // The quotient fits DIV_QB bits, so the top numerator bits stay below the divisor.
      assign rem_src[k] = 8'(num[DIV_NW-1:DIV_QB]);
      assign n_src[k]   = num[DIV_QB-1:0];
      assign q_src[k]   = '0;
      assign d_src[k]   = den;
    end else begin : g_next
      assign rem_src[k] = rem_r[k-1];
      assign n_src[k]   = n_r[k-1];
      assign q_src[k]   = q_r[k-1];
      assign d_src[k]   = d_r[k-1];
    end

    always_comb begin
      logic [7:0]        rem;
      logic [DIV_QB-1:0] n;
      logic [DIV_QB-1:0] q;
      logic [8:0]        t;
      rem = rem_src[k];
      n   = n_src[k];
      q   = q_src[k];
      for (int j = 0; j < DIV_STEPS; j++) begin
        t = {rem, n[DIV_QB-1]};
        n = {n[DIV_QB-2:0], 1'b0};
        if (t >= {1'b0, d_src[k]}) begin
          t = t - {1'b0, d_src[k]};
          q = {q[DIV_QB-2:0], 1'b1};
        end else begin
          q = {q[DIV_QB-2:0], 1'b0};
        end
        rem = t[7:0];
      end
      rem_nxt[k] = rem;
      n_nxt[k]   = n;
      q_nxt[k]   = q;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rem_nxt[k];
        n_r[k]   <= n_nxt[k];
        q_r[k]   <= q_nxt[k];
        d_r[k]   <= d_src[k];
      end
    end
  end

  assign quo = q_r[DIV_STAGES-1];

endmodule

>>> src/hci_mix.sv
// Hue assembly, shortest-arc hue blend and linear saturation and value blend.
module hci_mix (
  input  logic                           clk,
  input  logic [hci_pkg::MIX_STAGES-1:0] en,
  input  logic [hci_pkg::DIV_QB-1:0]     qs_a,
  input  logic [hci_pkg::DIV_QB-1:0]     qh_a,
  input  logic [hci_pkg::DIV_QB-1:0]     qs_b,
  input  logic [hci_pkg::DIV_QB-1:0]     qh_b,
  input  hci_pkg::side_t                 side,
  output hci_pkg::mid_t                  mid
);
  import hci_pkg::*;

  function automatic logic [14:0] hue_of(hsv_side_t sd, logic [DIV_QB-1:0] part);
    logic [14:0] p;
    logic [14:0] h;
    p = part[14:0];
    unique case (sd.sel)
      SEL_RED:   h = sd.neg ? ((p == 15'd0) ? 15'd0 : 15'(HUE_FULL) - p) : p;
      SEL_GREEN: h = sd.neg ? 15'(2 * HUE_SECTOR) - p : 15'(2 * HUE_SECTOR) + p;
      SEL_BLUE:  h = sd.neg ? 15'(4 * HUE_SECTOR) - p : 15'(4 * HUE_SECTOR) + p;
      default:   h = 15'd0;
    endcase
    if (sd.dzero) h = 15'd0;
    return h;
  endfunction

  // First stage: hues and wrapped hue difference.
  logic [14:0]        ha_r, ha_nxt, hb;
  logic signed [14:0] dh_r, dh_nxt;
  logic signed [15:0] d0;
  logic [16:0]        sa_r, sa_nxt, sb_r, sb_nxt, va_r, vb_r;
  logic [15:0]        w_r;
  logic               byp1_r;
  logic [23:0]        pass1_r;

  always_comb begin
    ha_nxt = hue_of(side.a, qh_a);
    hb     = hue_of(side.b, qh_b);
    sa_nxt = side.a.dzero ? 17'd0 : qs_a[16:0];
    sb_nxt = side.b.dzero ? 17'd0 : qs_b[16:0];
    d0     = $signed({1'b0, hb}) - $signed({1'b0, ha_nxt});
    if (d0 > 16'sd11520) d0 = d0 - 16'sd23040;
    if (d0 < -16'sd11520) d0 = d0 + 16'sd23040;
    dh_nxt = d0[14:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ha_r    <= ha_nxt;
      dh_r    <= dh_nxt;
      sa_r    <= sa_nxt;
      sb_r    <= sb_nxt;
      va_r    <= side.a.v;
      vb_r    <= side.b.v;
      w_r     <= side.w;
      byp1_r  <= side.bypass;
      pass1_r <= side.pass;
    end
  end

  // Second stage: weighted differences.
  logic signed [31:0] ph_r, ph_nxt;
  logic signed [34:0] ps_r, ps_nxt, pv_r, pv_nxt;
  logic signed [17:0] ds, dv;
  logic signed [16:0] ws;
  logic [14:0]        ha2_r;
  logic [16:0]        sa2_r, va2_r;
  logic               byp2_r;
  logic [23:0]        pass2_r;

  always_comb begin
    ws     = $signed({1'b0, w_r});
    ds     = $signed({1'b0, sb_r}) - $signed({1'b0, sa_r});
    dv     = $signed({1'b0, vb_r}) - $signed({1'b0, va_r});
    ph_nxt = dh_r * ws;
    ps_nxt = ds * ws;
    pv_nxt = dv * ws;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ph_r    <= ph_nxt;
      ps_r    <= ps_nxt;
      pv_r    <= pv_nxt;
      ha2_r   <= ha_r;
      sa2_r   <= sa_r;
      va2_r   <= va_r;
      byp2_r  <= byp1_r;
      pass2_r <= pass1_r;
    end
  end

  // Third stage: rounding, hue wrap.
  mid_t               mid_r, mid_nxt;
  logic signed [33:0] hacc;
  logic [15:0]        hoff;
  logic [17:0]        u;
  logic signed [35:0] ts, tv, ms, mv;

  always_comb begin
    hoff = 16'(ha2_r) + 16'(HUE_FULL);
    hacc = $signed({2'b00, hoff, 16'h0000}) + 34'(ph_r) + 34'sd32768;
    u    = hacc[33:16];
    if (u >= 18'(2 * HUE_FULL)) u = u - 18'(2 * HUE_FULL);
    else if (u >= 18'(HUE_FULL)) u = u - 18'(HUE_FULL);
    ts = (36'(ps_r) + 36'sd32768) >>> 16;
    tv = (36'(pv_r) + 36'sd32768) >>> 16;
    ms = $signed({19'd0, sa2_r}) + ts;
    mv = $signed({19'd0, va2_r}) + tv;
    mid_nxt.h      = u[14:0];
    mid_nxt.s      = ms[16:0];
    mid_nxt.v      = mv[16:0];
    mid_nxt.bypass = byp2_r;
    mid_nxt.pass   = pass2_r;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid = mid_r;

endmodule

>>> src/hci_rgb.sv
// HSV to RGB back conversion with round-to-nearest, ending in the output registers.
module hci_rgb (
  input  logic                           clk,
  input  logic [hci_pkg::RGB_STAGES-1:0] en,
  input  hci_pkg::mid_t                  mid,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue
);
  import hci_pkg::*;

  localparam logic [53:0] BYTE_HALF = 54'(HUE_SECTOR / 2) << 32;

  // First stage: sector, fraction and saturation products.
  logic [2:0]  i1_r, i1_nxt;
  logic [11:0] f;
  logic [14:0] base;
  logic [28:0] sf_r, sf_nxt, sg_r, sg_nxt;
  logic [16:0] s1_r, v1_r;
  logic        szero1_r, byp1_r;
  logic [23:0] pass1_r;

  always_comb begin
    priority if (mid.h >= 15'(5 * HUE_SECTOR)) i1_nxt = 3'd5;
    else if (mid.h >= 15'(4 * HUE_SECTOR)) i1_nxt = 3'd4;
    else if (mid.h >= 15'(3 * HUE_SECTOR)) i1_nxt = 3'd3;
    else if (mid.h >= 15'(2 * HUE_SECTOR)) i1_nxt = 3'd2;
    else if (mid.h >= 15'(HUE_SECTOR)) i1_nxt = 3'd1;
    else i1_nxt = 3'd0;
    base   = 15'(i1_nxt) * 15'(HUE_SECTOR);
    f      = 12'(mid.h - base);
    sf_nxt = 29'(mid.s) * 29'(f);
    sg_nxt = 29'(mid.s) * 29'(12'(HUE_SECTOR) - f);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      i1_r     <= i1_nxt;
      sf_r     <= sf_nxt;
      sg_r     <= sg_nxt;
      s1_r     <= mid.s;
      v1_r     <= mid.v;
      szero1_r <= (mid.s == 17'd0);
      byp1_r   <= mid.bypass;
      pass1_r  <= mid.pass;
    end
  end

  // Second stage: p, q, t terms and channel selection.
  logic [27:0] xv, xp, xq, xt;
  logic [16:0] ns;
  logic [24:0] gt;
  logic [27:0] xr_r, xr_nxt, xg_r, xg_nxt, xb_r, xb_nxt;
  logic [16:0] v2_r;
  logic [7:0]  gray2_r;
  logic        szero2_r, byp2_r;
  logic [23:0] pass2_r;

  always_comb begin
    ns = 17'(Q16_ONE) - s1_r;
    xv = 28'(HSV_FULL);
    xp = 28'(ns) * 28'(HUE_SECTOR);
    xq = 28'(HSV_FULL) - sf_r[27:0];
    xt = 28'(HSV_FULL) - sg_r[27:0];
    unique case (i1_r)
      3'd0:    begin xr_nxt = xv; xg_nxt = xt; xb_nxt = xp; end
      3'd1:    begin xr_nxt = xq; xg_nxt = xv; xb_nxt = xp; end
      3'd2:    begin xr_nxt = xp; xg_nxt = xv; xb_nxt = xt; end
      3'd3:    begin xr_nxt = xp; xg_nxt = xq; xb_nxt = xv; end
      3'd4:    begin xr_nxt = xt; xg_nxt = xp; xb_nxt = xv; end
      default: begin xr_nxt = xv; xg_nxt = xp; xb_nxt = xq; end
    endcase
    gt = 25'(v1_r) * 25'd255 + 25'd32768;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xr_r     <= xr_nxt;
      xg_r     <= xg_nxt;
      xb_r     <= xb_nxt;
      v2_r     <= v1_r;
      gray2_r  <= gt[23:16];
      szero2_r <= szero1_r;
      byp2_r   <= byp1_r;
      pass2_r  <= pass1_r;
    end
  end

  // Third stage: scale by value.
  logic [44:0] nr_r, ng_r, nb_r;
  logic [7:0]  gray3_r;
  logic        szero3_r, byp3_r;
  logic [23:0] pass3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      nr_r     <= 45'(v2_r) * 45'(xr_r);
      ng_r     <= 45'(v2_r) * 45'(xg_r);
      nb_r     <= 45'(v2_r) * 45'(xb_r);
      gray3_r  <= gray2_r;
      szero3_r <= szero2_r;
      byp3_r   <= byp2_r;
      pass3_r  <= pass2_r;
    end
  end

  // Fourth stage: times 255, round and drop the power-of-two part of the divisor.
  logic [53:0] zr, zg, zb;
  logic [13:0] yr_r, yg_r, yb_r;
  logic [7:0]  gray4_r;
  logic        szero4_r, byp4_r;
  logic [23:0] pass4_r;

  always_comb begin
    zr = 54'(nr_r) * 54'd255 + BYTE_HALF;
    zg = 54'(ng_r) * 54'd255 + BYTE_HALF;
    zb = 54'(nb_r) * 54'd255 + BYTE_HALF;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      yr_r     <= zr[53:40];
      yg_r     <= zg[53:40];
      yb_r     <= zb[53:40];
      gray4_r  <= gray3_r;
      szero4_r <= szero3_r;
      byp4_r   <= byp3_r;
      pass4_r  <= pass3_r;
    end
  end

  // Fifth stage: divide by fifteen through a reciprocal with one correction.
  function automatic logic [7:0] div15(logic [13:0] y);
    logic [26:0] qm;
    logic [8:0]  q;
    logic [13:0] r;
    qm = 27'(y) * 27'd4369;
    q  = qm[24:16];
    r  = y - 14'(q) * 14'd15;
    if (r >= 14'd15) q = q + 9'd1;
    return q[7:0];
  endfunction

  logic [7:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;

  always_comb begin
    if (byp4_r) begin
      red_nxt   = pass4_r[23:16];
      green_nxt = pass4_r[15:8];
      blue_nxt  = pass4_r[7:0];
    end else if (szero4_r) begin
      red_nxt   = gray4_r;
      green_nxt = gray4_r;
      blue_nxt  = gray4_r;
    end else begin
      red_nxt   = div15(yr_r);
      green_nxt = div15(yg_r);
      blue_nxt  = div15(yb_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

>>> src/hsv_color_interpolator.sv
// Top level of the HSV colour interpolator: a fifteen-stage pipeline from item in to item out.
// Throughput is one item per cycle while the output is not stalled; the six-stage hue
// and saturation dividers set the depth.
// A stalled output holds its item while empty stages further up keep taking new items.
// Reset (rst_n low, synchronous) clears every stage valid bit; the data registers are not reset.
module hsv_color_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_from_red,
  input  logic [7:0]  in_from_green,
  input  logic [7:0]  in_from_blue,
  input  logic [7:0]  in_to_red,
  input  logic [7:0]  in_to_green,
  input  logic [7:0]  in_to_blue,
  input  logic [16:0] in_blend,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);
  import hci_pkg::*;

  localparam int MIX_BASE = 1 + DIV_STAGES;
  localparam int RGB_BASE = MIX_BASE + MIX_STAGES;

  // Valid bits travel with the data. A stage loads whenever it is empty or the stage
  // after it loads too, so bubbles are squeezed out while the output is stalled.
  logic [N_STAGES-1:0] vld_r, vld_nxt, en;

  assign en[N_STAGES-1] = !vld_r[N_STAGES-1] || out_ready;
  for (genvar k = 0; k < N_STAGES - 1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < N_STAGES; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[N_STAGES-1];

  // Stage zero: both colours go through the front end of the HSV conversion. A blend of
  // zero passes the start colour through untouched, one or more passes the end colour.
  logic [DIV_NW-1:0] snum_a, hnum_a, snum_b, hnum_b;
  logic [7:0]        sden_a, hden_a, sden_b, hden_b;
  hsv_side_t         hs_a, hs_b;
  side_t             side_nxt;

  hci_front u_front_a (
    .red   (in_from_red),
    .green (in_from_green),
    .blue  (in_from_blue),
    .s_num (snum_a),
    .h_num (hnum_a),
    .s_den (sden_a),
    .h_den (hden_a),
    .side  (hs_a)
  );

  hci_front u_front_b (
    .red   (in_to_red),
    .green (in_to_green),
    .blue  (in_to_blue),
    .s_num (snum_b),
    .h_num (hnum_b),
    .s_den (sden_b),
    .h_den (hden_b),
    .side  (hs_b)
  );

  always_comb begin
    side_nxt.a      = hs_a;
    side_nxt.b      = hs_b;
    side_nxt.w      = in_blend[15:0];
    side_nxt.bypass = (in_blend == 17'd0) || in_blend[16];
    side_nxt.pass   = (in_blend == 17'd0) ? {in_from_red, in_from_green, in_from_blue}
                                          : {in_to_red, in_to_green, in_to_blue};
  end

  logic [DIV_NW-1:0] snum_a_r, hnum_a_r, snum_b_r, hnum_b_r;
  logic [7:0]        sden_a_r, hden_a_r, sden_b_r, hden_b_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      snum_a_r <= snum_a;
      hnum_a_r <= hnum_a;
      snum_b_r <= snum_b;
      hnum_b_r <= hnum_b;
      sden_a_r <= sden_a;
      hden_a_r <= hden_a;
      sden_b_r <= sden_b;
      hden_b_r <= hden_b;
    end
  end

  // Side information waits alongside the dividers.
  side_t side_r [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= side_nxt;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Stages one to six: saturation and hue fraction of both colours.
  logic [DIV_QB-1:0] qs_a, qh_a, qs_b, qh_b;

  hci_div u_div_sa (
    .clk (clk), .en (en[DIV_STAGES:1]), .num (snum_a_r), .den (sden_a_r), .quo (qs_a)
  );
  hci_div u_div_ha (
    .clk (clk), .en (en[DIV_STAGES:1]), .num (hnum_a_r), .den (hden_a_r), .quo (qh_a)
  );
  hci_div u_div_sb (
    .clk (clk), .en (en[DIV_STAGES:1]), .num (snum_b_r), .den (sden_b_r), .quo (qs_b)
  );
  hci_div u_div_hb (
    .clk (clk), .en (en[DIV_STAGES:1]), .num (hnum_b_r), .den (hden_b_r), .quo (qh_b)
  );

  // Three stages of blending, then five of conversion back to RGB.
  mid_t mid;

  hci_mix u_mix (
    .clk  (clk),
    .en   (en[MIX_BASE +: MIX_STAGES]),
    .qs_a (qs_a),
    .qh_a (qh_a),
    .qs_b (qs_b),
    .qh_b (qh_b),
    .side (side_r[DIV_STAGES]),
    .mid  (mid)
  );

  hci_rgb u_rgb (
    .clk   (clk),
    .en    (en[RGB_BASE +: RGB_STAGES]),
    .mid   (mid),
    .red   (out_red),
    .green (out_green),
    .blue  (out_blue)
  );

  // With the output free every stage can move, so the pipeline takes an item.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input not ready although the output is free");

  // An accepted item lands in stage zero.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted item lost at stage zero");

  // A full stage that cannot move keeps its item.
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[RGB_BASE] && !en[RGB_BASE]) |=> vld_r[RGB_BASE])
    else $error("stalled stage dropped its item");

endmodule

>>> bench/tb.sv
// Self-checking bench for the HSV colour interpolator, with its own blend predictor.
module tb;

  // Clock, reset and the ports of the block under test.
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_from_red;
  logic [7:0]  in_from_green;
  logic [7:0]  in_from_blue;
  logic [7:0]  in_to_red;
  logic [7:0]  in_to_green;
  logic [7:0]  in_to_blue;
  logic [16:0] in_blend;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;

  // One colour pair with its blend fraction, as offered on the input side.
  typedef struct packed {
    logic [7:0]  fr, fg, fb, tr, tg, tb;
    logic [16:0] w;
  } pair_t;

  // The colour that the block should return for one pair.
  typedef struct packed {
    logic [7:0] r, g, b;
  } colour_t;

  // Hue in 1/64 degree, saturation and value in Q16.
  typedef struct {
    longint h, s, v;
  } hsv_t;

  localparam longint SECTOR = 3840;
  localparam longint FULL_TURN = 23040;
  localparam longint HALF_TURN = 11520;
  localparam longint ONE = 65536;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  pair_t   pending_pairs[$];
  colour_t expected_colours[$];

  int  cycle_count;
  int  mismatch_count;
  int  results_seen;
  int  pairs_sent;
  bit  stimulus_done;
  bit  no_idle;      // the idle-free stretch switches off random gaps on both sides
  int  hold_off;     // remaining cycles of a long receiver hold-off
  bit  hold_request; // the stimulus asks the receiver for a hold-off
  bit  sender_pause; // the sender waits until every expected result has come

  hsv_color_interpolator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_from_red   (in_from_red),
    .in_from_green (in_from_green),
    .in_from_blue  (in_from_blue),
    .in_to_red     (in_to_red),
    .in_to_green   (in_to_green),
    .in_to_blue    (in_to_blue),
    .in_blend      (in_blend),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Converts one 8-bit colour to fixed-point HSV. The sector is chosen by the
  // largest channel, tested red first, then green, then blue; the hue part is
  // rounded on its magnitude so that the sign is restored afterwards.
  function automatic hsv_t colour_to_hsv(longint r, longint g, longint b);
    hsv_t   o;
    longint mx, mn, dl, hi, lo, mag, part;
    bit     neg;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    o.v = (mx * ONE + 127) / 255;
    o.h = 0;
    o.s = 0;
    if (dl == 0) return o;
    o.s = (dl * ONE + mx / 2) / mx;
    if (mx == r) begin
      hi = g; lo = b;
    end else if (mx == g) begin
      hi = b; lo = r;
    end else begin
      hi = r; lo = g;
    end
    neg = lo > hi;
    mag = neg ? lo - hi : hi - lo;
    part = (SECTOR * mag + dl / 2) / dl;
    if (mx == r) o.h = neg ? ((part == 0) ? 0 : FULL_TURN - part) : part;
    else if (mx == g) o.h = neg ? 2 * SECTOR - part : 2 * SECTOR + part;
    else o.h = neg ? 4 * SECTOR - part : 4 * SECTOR + part;
    return o;
  endfunction

  // Scales an exact HSV channel product back to a byte, rounding half up.
  function automatic logic [7:0] channel_byte(longint unsigned x);
    longint unsigned den;
    den = 64'(SECTOR) << 32;
    return 8'((x * 255 + den / 2) / den);
  endfunction

  // Works out the blended colour for one pair.
  function automatic colour_t blend_colour(pair_t p);
    colour_t         c;
    hsv_t            a, b;
    longint          dh, acc, mh, ms, mv, w, i, f;
    longint unsigned v, pp, q, t, full, rr, gg, bb, grey;
    w = p.w;
    if (w == 0) begin
      c.r = p.fr; c.g = p.fg; c.b = p.fb;
      return c;
    end
    if (w >= ONE) begin
      c.r = p.tr; c.g = p.tg; c.b = p.tb;
      return c;
    end
    a = colour_to_hsv(p.fr, p.fg, p.fb);
    b = colour_to_hsv(p.tr, p.tg, p.tb);
    // Hue travels along the shorter arc of the circle.
    dh = b.h - a.h;
    if (dh > HALF_TURN) dh -= FULL_TURN;
    if (dh < -HALF_TURN) dh += FULL_TURN;
    acc = (a.h + FULL_TURN) * ONE + dh * w + 32768;
    mh = acc >>> 16;
    while (mh >= FULL_TURN) mh -= FULL_TURN;
    ms = (a.s * (ONE - w) + b.s * w + 32768) >>> 16;
    mv = (a.v * (ONE - w) + b.v * w + 32768) >>> 16;
    if (ms == 0) begin
      grey = (mv * 255 + 32768) >> 16;
      c.r = 8'(grey); c.g = 8'(grey); c.b = 8'(grey);
      return c;
    end
    i = mh / SECTOR;
    f = mh % SECTOR;
    full = ONE * SECTOR;
    v  = mv * full;
    pp = mv * (ONE - ms) * SECTOR;
    q  = mv * (full - ms * f);
    t  = mv * (full - ms * (SECTOR - f));
    case (i)
      0: begin rr = v;  gg = t;  bb = pp; end
      1: begin rr = q;  gg = v;  bb = pp; end
      2: begin rr = pp; gg = v;  bb = t;  end
      3: begin rr = pp; gg = q;  bb = v;  end
      4: begin rr = t;  gg = pp; bb = v;  end
      default: begin rr = v; gg = pp; bb = q; end
    endcase
    c.r = channel_byte(rr);
    c.g = channel_byte(gg);
    c.b = channel_byte(bb);
    return c;
  endfunction

  function automatic pair_t make_pair(logic [7:0] fr, fg, fb, tr, tg, tb, logic [16:0] w);
    pair_t p;
    p.fr = fr; p.fg = fg; p.fb = fb;
    p.tr = tr; p.tg = tg; p.tb = tb;
    p.w  = w;
    return p;
  endfunction

  // Random blend fraction. Most lie strictly inside the interval, where the
  // HSV path is exercised; the ends and values beyond one are mixed in.
  function automatic logic [16:0] random_blend();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 4) return 17'd0;
    if (k < 8) return 17'(ONE);
    if (k < 12) return 17'($urandom_range(131071, 65536));
    if (k < 18) return 17'($urandom_range(8, 1));
    if (k < 24) return 17'($urandom_range(65535, 65528));
    return 17'($urandom_range(65535, 1));
  endfunction

  // Random colour, sometimes grey or with a tied largest channel so that the
  // sector order and the zero-delta case come up often.
  function automatic logic [23:0] random_colour();
    logic [7:0] r, g, b;
    int unsigned k;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    k = $urandom_range(9);
    if (k == 0) begin
      g = r; b = r;
    end else if (k == 1) begin
      g = r;
    end else if (k == 2) begin
      b = g;
    end else if (k == 3) begin
      b = r;
    end
    return {r, g, b};
  endfunction

  // Directed pairs first, then the random part. The input queue is filled
  // in bursts so that the pressure phases can be placed between them.
  initial begin
    logic [23:0] ca, cb;
    int          n;
    stimulus_done = 1'b0;
    hold_request  = 1'b0;
    sender_pause  = 1'b0;
    // Both ends of the blend, and values beyond one.
    pending_pairs.push_back(make_pair(8'hff, 8'h00, 8'h80, 8'h01, 8'hfe, 8'h7f, 17'd0));
    pending_pairs.push_back(make_pair(8'h12, 8'h34, 8'h56, 8'hab, 8'hcd, 8'hef, 17'(ONE)));
    pending_pairs.push_back(make_pair(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 17'h1ffff));
    pending_pairs.push_back(make_pair(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 17'd1));
    pending_pairs.push_back(make_pair(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 17'd65535));
    // Grey into a saturated colour, and grey into grey.
    pending_pairs.push_back(make_pair(8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'hff, 17'd32768));
    pending_pairs.push_back(make_pair(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 17'd32768));
    // Each sector choice, including ties between the largest channels.
    pending_pairs.push_back(make_pair(8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 17'd16384));
    pending_pairs.push_back(make_pair(8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 17'd49152));
    pending_pairs.push_back(make_pair(8'h00, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00, 17'd32768));
    pending_pairs.push_back(make_pair(8'hff, 8'hff, 8'h00, 8'h00, 8'hff, 8'hff, 17'd20000));
    pending_pairs.push_back(make_pair(8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 17'd40000));
    // Red sector with a negative hue part, wrapping across zero degrees.
    pending_pairs.push_back(make_pair(8'hff, 8'h00, 8'h10, 8'hff, 8'h10, 8'h00, 17'd32768));
    pending_pairs.push_back(make_pair(8'hff, 8'h00, 8'h40, 8'h40, 8'hff, 8'h00, 17'd60000));
    // Hues exactly half a turn apart, and the shorter arc both ways.
    pending_pairs.push_back(make_pair(8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 17'd32768));
    pending_pairs.push_back(make_pair(8'h00, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 17'd32768));
    pending_pairs.push_back(make_pair(8'hff, 8'h00, 8'h80, 8'hff, 8'h80, 8'h00, 17'd100));
    pending_pairs.push_back(make_pair(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 17'd65000));
    pending_pairs.push_back(make_pair(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 17'd43690));

    @(posedge clk);
    wait (rst_n);
    // Random part in bursts of two hundred pairs.
    for (n = 0; n < 1800; n++) begin
      ca = random_colour();
      cb = random_colour();
      pending_pairs.push_back(make_pair(ca[23:16], ca[15:8], ca[7:0],
                                        cb[23:16], cb[15:8], cb[7:0], random_blend()));
      if (n % 200 == 199) begin
        wait (pending_pairs.size() < 20);
        @(posedge clk);
      end
      // A long receiver hold-off while the sender keeps offering pairs.
      if (n == 600) hold_request = 1'b1;
      // One pause of the sender until every expected colour has come back.
      if (n == 1200) begin
        wait (pending_pairs.size() == 0 && !in_valid);
        sender_pause = 1'b1;
        wait (expected_colours.size() == 0);
        @(posedge clk);
        sender_pause = 1'b0;
      end
    end
    stimulus_done = 1'b1;
  end

  // Driver: offers the head of the queue and keeps it stable until accepted.
  always @(posedge clk) begin
    pair_t p;
    bit    accepted;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && in_ready;
      if (accepted) begin
        expected_colours.push_back(blend_colour(pending_pairs.pop_front()));
        pairs_sent++;
      end
      if (!in_valid || accepted) begin
        if (pending_pairs.size() != 0 && !sender_pause &&
            (no_idle || $urandom_range(99) >= 28)) begin
          p = pending_pairs[0];
          in_valid      <= 1'b1;
          in_from_red   <= p.fr;
          in_from_green <= p.fg;
          in_from_blue  <= p.fb;
          in_to_red     <= p.tr;
          in_to_green   <= p.tg;
          in_to_blue    <= p.tb;
          in_blend      <= p.w;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: random stalls, an idle-free stretch in the middle of
  // the run, and one long hold-off counted here so the pipeline fills up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_off  <= 0;
    end else if (hold_request && hold_off == 0) begin
      hold_request <= 1'b0;
      hold_off     <= 300;
      out_ready    <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_ready <= (hold_off == 1);
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 28);
    end
  end

  // Monitor: compares each accepted colour with the oldest expectation.
  always @(posedge clk) begin
    colour_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_colours.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result %0d: r=%0d g=%0d b=%0d", results_seen,
                   out_red, out_green, out_blue);
      end else begin
        want = expected_colours.pop_front();
        if (out_red !== want.r || out_green !== want.g || out_blue !== want.b) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result %0d wrong: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     results_seen, want.r, want.g, want.b, out_red, out_green, out_blue);
        end
      end
    end
  end

  // Cycle counter with a generous limit against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    no_idle <= (cycle_count > 1400 && cycle_count < 1900);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Reset, then wait for all stimulus and results before the verdict.
  initial begin
    cycle_count    = 0;
    mismatch_count = 0;
    results_seen   = 0;
    pairs_sent     = 0;
    no_idle        = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    out_ready      = 1'b0;
    in_from_red    = '0;
    in_from_green  = '0;
    in_from_blue   = '0;
    in_to_red      = '0;
    in_to_green    = '0;
    in_to_blue     = '0;
    in_blend       = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && pending_pairs.size() == 0 && !in_valid);
    wait (expected_colours.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Blended %0d colour pairs through the HSV path and bypasses, %0d compared.",
             pairs_sent, results_seen);
    $display("Covered both blend ends, grey colours, hue wrap and a full pipeline stall.");
    if (mismatch_count == 0 && expected_colours.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("Failures: %0d", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
